// ===== rtl/twm_pkg.sv =====
// ----------------------------------------------------------------------------
// twm_pkg
// Types and constants of the track window matcher: operation codes, register
// indexes, window reset values and the stored track entry.
// ----------------------------------------------------------------------------
package twm_pkg;

	// operation codes carried by func
	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PT_WINDOW  = 2'd0;
	localparam logic [1:0] REG_ETA_WINDOW = 2'd1;
	localparam logic [1:0] REG_PHI_WINDOW = 2'd2;

	// window reset values
	localparam logic [15:0] PT_WINDOW_RST  = 16'd1600;
	localparam logic [12:0] ETA_WINDOW_RST = 13'd410;
	localparam logic [11:0] PHI_WINDOW_RST = 12'd587;

	// running minima start above any difference and never pass a window
	localparam logic [16:0] MIN_PT_START  = 17'd65536;
	localparam logic [13:0] MIN_ETA_START = 14'd8192;
	localparam logic [11:0] MIN_PHI_START = 12'd4095;

	typedef struct packed {
		logic [15:0]        pt;
		logic signed [12:0] eta;
		logic [11:0]        phi;
	} track_t;

endpackage

// ===== rtl/track_window_matcher.sv =====
// ----------------------------------------------------------------------------
// track_window_matcher
// Keeps a table of tracks and matches a candidate against it, walking the
// stored tracks through one shared difference and compare unit.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  func, pt_value, eta_value, phi_value
//   out      output     out_valid/out_ready  found, track_index
//   cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// Clear and append complete without leaving the idle state. A query walks the
// table with one table read per cycle feeding the compare unit, then drains.
// After reset the table is empty and the windows hold their reset values.
// A finished query result waits in the output register while the next
// transaction is accepted; a second query holds its result until that slot
// is free.
// ----------------------------------------------------------------------------
module track_window_matcher #(
	parameter int MAX_TRACKS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [15:0]        pt_value,
	input  logic signed [12:0] eta_value,
	input  logic [11:0]        phi_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [7:0]         track_index,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int IdxW = $clog2(MAX_TRACKS);
	localparam int CntW = IdxW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [CntW-1:0]     count_q;
	logic [IdxW-1:0]     rd_idx_q;
	logic                cmp_vld_s1;
	logic [IdxW-1:0]     cmp_idx_s1;
	twm_pkg::track_t     rd_data_s1;
	twm_pkg::track_t     track_mem [MAX_TRACKS];

	logic [15:0]         pt_window_q;
	logic [12:0]         eta_window_q;
	logic [11:0]         phi_window_q;

	logic [15:0]         q_pt_q;
	logic signed [12:0]  q_eta_q;
	logic [11:0]         q_phi_q;

	logic [16:0]         min_pt_q;
	logic [13:0]         min_eta_q;
	logic [11:0]         min_phi_q;
	logic [IdxW-1:0]     best_q;

	logic                out_valid_q;
	logic                found_q;
	logic [7:0]          track_index_q;

	logic                in_acc;
	logic                wr_en;
	logic                issue_last;
	logic [15:0]         dpt;
	logic signed [13:0]  eta_sub;
	logic [12:0]         deta;
	logic [11:0]         phi_sub;
	logic [11:0]         dphi;
	logic                lpt, leta, lphi;
	logic                hpt, heta, hphi;
	logic                upd;
	logic                ok;
	logic [IdxW+7:0]     best_ext;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign wr_en       = in_acc && (func == twm_pkg::FUNC_APPEND)
		&& (count_q < CntW'(MAX_TRACKS));
	assign issue_last  = (({1'b0, rd_idx_q} + CntW'(1)) == count_q);

	// shared difference and compare unit
	always_comb begin
		dpt     = (q_pt_q >= rd_data_s1.pt) ? (q_pt_q - rd_data_s1.pt)
			: (rd_data_s1.pt - q_pt_q);
		eta_sub = {q_eta_q[12], q_eta_q} - {rd_data_s1.eta[12], rd_data_s1.eta};
		deta    = eta_sub[13] ? 13'(-eta_sub) : eta_sub[12:0];
		// phi wraps at a full turn
		phi_sub = q_phi_q - rd_data_s1.phi;
		dphi    = phi_sub[11] ? (12'd0 - phi_sub) : phi_sub;
		lpt     = {1'b0, dpt} < min_pt_q;
		leta    = {1'b0, deta} < min_eta_q;
		lphi    = dphi < min_phi_q;
		hpt     = {dpt, 1'b0} < {1'b0, pt_window_q};
		heta    = {deta, 1'b0} < {1'b0, eta_window_q};
		hphi    = {1'b0, dphi, 1'b0} < {2'b00, phi_window_q};
		upd     = cmp_vld_s1 && ((lpt && leta && lphi) || (lpt && heta && hphi)
			|| (leta && hpt && hphi) || (lphi && hpt && heta));
		ok      = (min_pt_q < {1'b0, pt_window_q})
			&& (min_eta_q < {1'b0, eta_window_q})
			&& (min_phi_q < phi_window_q);
		best_ext = {8'd0, best_q};
	end

	// track table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			track_mem[count_q[IdxW-1:0]] <= '{pt: pt_value, eta: eta_value, phi: phi_value};
		end
		rd_data_s1 <= track_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			rd_idx_q      <= '0;
			cmp_vld_s1    <= 1'b0;
			cmp_idx_s1    <= '0;
			pt_window_q   <= twm_pkg::PT_WINDOW_RST;
			eta_window_q  <= twm_pkg::ETA_WINDOW_RST;
			phi_window_q  <= twm_pkg::PHI_WINDOW_RST;
			q_pt_q        <= '0;
			q_eta_q       <= '0;
			q_phi_q       <= '0;
			min_pt_q      <= twm_pkg::MIN_PT_START;
			min_eta_q     <= twm_pkg::MIN_ETA_START;
			min_phi_q     <= twm_pkg::MIN_PHI_START;
			best_q        <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			track_index_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					twm_pkg::REG_PT_WINDOW:  pt_window_q  <= cfg_data;
					twm_pkg::REG_ETA_WINDOW: eta_window_q <= cfg_data[12:0];
					twm_pkg::REG_PHI_WINDOW: phi_window_q <= cfg_data[11:0];
					default: ;
				endcase
			end

			// the finish state loads the next result itself
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			cmp_vld_s1 <= (state_q == ST_WALK);
			cmp_idx_s1 <= rd_idx_q;

			if (upd) begin
				min_pt_q  <= {1'b0, dpt};
				min_eta_q <= {1'b0, deta};
				min_phi_q <= dphi;
				best_q    <= cmp_idx_s1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (func)
							twm_pkg::FUNC_CLEAR: count_q <= '0;
							twm_pkg::FUNC_APPEND: begin
								if (wr_en) begin
									count_q <= count_q + CntW'(1);
								end
							end
							twm_pkg::FUNC_QUERY: begin
								q_pt_q    <= pt_value;
								q_eta_q   <= eta_value;
								q_phi_q   <= phi_value;
								min_pt_q  <= twm_pkg::MIN_PT_START;
								min_eta_q <= twm_pkg::MIN_ETA_START;
								min_phi_q <= twm_pkg::MIN_PHI_START;
								best_q    <= '0;
								rd_idx_q  <= '0;
								state_q   <= (count_q == '0) ? ST_FINISH : ST_WALK;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					rd_idx_q <= rd_idx_q + IdxW'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last entry is compared in this cycle
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						found_q       <= ok;
						track_index_q <= ok ? best_ext[7:0] : 8'd0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign track_index = track_index_q;

endmodule
